// ===== src/int4_group_dequant_dot_product_top_defines.svh =====
// ----------------------------------------------------------------------------
// int4 group dequant dot product - assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef INT4_GROUP_DEQUANT_DOT_PRODUCT_TOP_DEFINES_SVH
`define INT4_GROUP_DEQUANT_DOT_PRODUCT_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define IGDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define IGDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/igdq_pkg.sv =====
// ----------------------------------------------------------------------------
// igdq_pkg
// Types and constants shared by the int4 group dequant dot product block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package igdq_pkg;

  localparam int NIBBLES    = 8;
  localparam int NIB_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int WORD_W     = NIBBLES * NIB_W;
  localparam int ACT_W      = 32;
  localparam int SCALE_W    = 16;
  localparam int RW_W       = 16;
  localparam int NIBD_W     = NIB_W + 1;
  localparam int NS_W       = NIBD_W + SCALE_W;
  localparam int PROD_W     = NS_W + ACT_W;
  localparam int ACC_W      = 64;
  localparam int HALF_W     = ACC_W / 2;
  localparam int PLO_W      = HALF_W + RW_W;
  localparam int PHI_W      = HALF_W + RW_W + 1;
  localparam int FULL_W     = ACC_W + RW_W + 1;
  localparam int FRAC_SH    = 15;
  localparam int RND_W      = FULL_W - FRAC_SH;

  // mac sequence: issue slots 0..7, then drain the multiplier
  localparam int MAC_LAST   = NIBBLES + 1;
  localparam int CNT_W      = $clog2(MAC_LAST + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_APPLY_RW   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT = 1'd1;

  localparam logic [NIB_W-1:0]  ZERO_POINT_RST = 4'd8;
  localparam logic [FULL_W-1:0] ROUND_HALF     = FULL_W'(16384);
  localparam logic [ACC_W-1:0]  ACC_MAX        = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN        = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [NIBBLES-1:0][ACT_W-1:0] act_vec_t;
  typedef logic [NIBBLES-1:0][NIB_W-1:0] nib_vec_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [SLOT_W-1:0] slot_a;
    logic              mul;
    logic [SLOT_W-1:0] slot_b;
    logic              add;
    logic              acc_add;
    logic              wmul;
    logic              wrnd;
    logic              emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic apply;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/int4_group_dequant_dot_product_top.sv =====
// flow: an accepted item runs the mac and the accumulate; only a last word
//   goes on, through router weighting when it is on, to the output register
// intake: a new item is taken only in idle, after the previous one is done;
//   the single shared multiplier pair steps through the eight slots of each item
// reset: rst_n synchronous, active low; clears control, accumulator, flag and
//   config (router weighting off, zero point 8)
// ----------------------------------------------------------------------------
// int4_group_dequant_dot_product_top
// Grouped int4 weight dequantizing dot product for one output feature.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module int4_group_dequant_dot_product_top
  import igdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [WORD_W-1:0]         in_weight_word,
  input  logic signed [ACT_W-1:0]   in_act_0,
  input  logic signed [ACT_W-1:0]   in_act_1,
  input  logic signed [ACT_W-1:0]   in_act_2,
  input  logic signed [ACT_W-1:0]   in_act_3,
  input  logic signed [ACT_W-1:0]   in_act_4,
  input  logic signed [ACT_W-1:0]   in_act_5,
  input  logic signed [ACT_W-1:0]   in_act_6,
  input  logic signed [ACT_W-1:0]   in_act_7,
  input  logic signed [SCALE_W-1:0] in_group_scale,
  input  logic [RW_W-1:0]           in_router_weight,
  input  logic                      in_last_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ACC_W-1:0]   out_contribution,
  output logic                      out_saturated,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  dp_cmd_t  cmd;
  dp_sts_t  sts;
  act_vec_t in_act;

  assign in_act[0] = in_act_0;
  assign in_act[1] = in_act_1;
  assign in_act[2] = in_act_2;
  assign in_act[3] = in_act_3;
  assign in_act[4] = in_act_4;
  assign in_act[5] = in_act_5;
  assign in_act[6] = in_act_6;
  assign in_act[7] = in_act_7;

  igdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  igdq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_weight_word   (in_weight_word),
    .in_act           (in_act),
    .in_group_scale   (in_group_scale),
    .in_router_weight (in_router_weight),
    .in_last_word     (in_last_word),
    .out_contribution (out_contribution),
    .out_saturated    (out_saturated)
  );

endmodule

`default_nettype wire

// ===== src/igdq_dp.sv =====
// ----------------------------------------------------------------------------
// igdq_dp
// Datapath: item and config registers, nibble x scale x activation mac,
// saturating accumulator, router weighting and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module igdq_dp
  import igdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [WORD_W-1:0]         in_weight_word,
  input  act_vec_t                  in_act,
  input  logic signed [SCALE_W-1:0] in_group_scale,
  input  logic [RW_W-1:0]           in_router_weight,
  input  logic                      in_last_word,
  output logic signed [ACC_W-1:0]   out_contribution,
  output logic                      out_saturated
);

  logic                      apply_r;
  logic [NIB_W-1:0]          zp_r;
  nib_vec_t                  nib_r;
  act_vec_t                  act_r;
  logic signed [SCALE_W-1:0] scale_r;
  logic [RW_W-1:0]           rw_r;
  logic                      last_r;

  logic signed [NS_W-1:0]    ns_r;
  logic signed [NS_W-1:0]    ns_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic [ACC_W-1:0]          wsum_r;
  logic [ACC_W-1:0]          acc_r;
  logic [ACC_W-1:0]          acc_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic [PLO_W-1:0]          plo_r;
  logic signed [PHI_W-1:0]   phi_r;
  logic [RND_W-1:0]          rnd_r;
  logic [FULL_W-1:0]         full_sum;
  logic signed [NIBD_W-1:0]  nib_d;
  logic [ACC_W:0]            acc_sum;
  logic                      rnd_fits;
  logic [ACC_W-1:0]          wtd_val;
  logic [ACC_W-1:0]          res_val;
  logic                      res_sat;
  logic signed [ACC_W-1:0]   out_contribution_r;
  logic                      out_saturated_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_r <= 1'b0;
      zp_r    <= ZERO_POINT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_APPLY_RW:   apply_r <= cfg_wdata[0];
        CFG_ZERO_POINT: zp_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nib_r   <= nib_vec_t'(in_weight_word);
      act_r   <= in_act;
      scale_r <= in_group_scale;
      rw_r    <= in_router_weight;
      last_r  <= in_last_word;
    end
  end

  // stage a: (nibble - zero point) * scale, stage b: * activation
  always_comb begin
    nib_d    = $signed({1'b0, nib_r[cmd.slot_a]}) - $signed({1'b0, zp_r});
    ns_nxt   = NS_W'(nib_d) * NS_W'(scale_r);
    prod_nxt = PROD_W'(ns_r) * PROD_W'($signed(act_r[cmd.slot_b]));
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ns_r <= ns_nxt;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.load) begin
      wsum_r <= '0;
    end else if (cmd.add) begin
      wsum_r <= wsum_r + ACC_W'(prod_r);
    end
  end

  // saturating accumulate, cleared on emit
  always_comb begin
    acc_sum = {acc_r[ACC_W-1], acc_r} + {wsum_r[ACC_W-1], wsum_r};
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (cmd.emit) begin
      acc_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.acc_add) begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
        acc_nxt = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = acc_sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // router weighting: split 64x16 product into two halves, then round and clamp
  always_ff @(posedge clk) begin
    if (cmd.wmul) begin
      plo_r <= PLO_W'(acc_r[HALF_W-1:0]) * PLO_W'(rw_r);
      phi_r <= PHI_W'($signed(acc_r[ACC_W-1:HALF_W])) * PHI_W'($signed({1'b0, rw_r}));
    end
    if (cmd.wrnd) begin
      rnd_r <= full_sum[FULL_W-1:FRAC_SH];
    end
  end

  always_comb begin
    full_sum = (FULL_W'(phi_r) << HALF_W) + FULL_W'(plo_r) + ROUND_HALF;
    rnd_fits = (rnd_r[RND_W-1:ACC_W-1] == '0) || (rnd_r[RND_W-1:ACC_W-1] == '1);
    if (rnd_fits) begin
      wtd_val = rnd_r[ACC_W-1:0];
    end else begin
      wtd_val = rnd_r[RND_W-1] ? ACC_MIN : ACC_MAX;
    end
    res_val = apply_r ? wtd_val : acc_r;
    res_sat = ovf_r | (apply_r & ~rnd_fits);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_contribution_r <= $signed(res_val);
      out_saturated_r    <= res_sat;
    end
  end

  assign out_contribution = out_contribution_r;
  assign out_saturated    = out_saturated_r;
  assign sts.last         = last_r;
  assign sts.apply        = apply_r;

endmodule

`default_nettype wire

// ===== src/igdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// igdq_ctrl
// Controller: sequences the eight-slot mac, the accumulate, the optional
// router weighting and the hand-off into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "int4_group_dequant_dot_product_top_defines.svh"

module igdq_ctrl
  import igdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_WMUL = 3'd3;
  localparam logic [2:0] S_WRND = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_prev;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_xfer;
  logic             in_mac;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign in_mac   = (state_r == S_MAC);
  assign cnt_prev = cnt_r - CNT_W'(1);

  always_comb begin
    cmd         = '0;
    cmd.load    = in_xfer;
    cmd.issue   = in_mac && (cnt_r < CNT_W'(NIBBLES));
    cmd.slot_a  = cnt_r[SLOT_W-1:0];
    cmd.mul     = in_mac && (cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(NIBBLES));
    cmd.slot_b  = cnt_prev[SLOT_W-1:0];
    cmd.add     = in_mac && (cnt_r >= CNT_W'(2));
    cmd.acc_add = (state_r == S_ACC);
    cmd.wmul    = (state_r == S_WMUL);
    cmd.wrnd    = (state_r == S_WRND);
    cmd.emit    = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_MAC;
          cnt_nxt   = '0;
        end
      end
      S_MAC: begin
        if (cnt_r == CNT_W'(MAC_LAST)) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ACC: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.apply) begin
          state_nxt = S_WMUL;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WMUL: state_nxt = S_WRND;
      S_WRND: state_nxt = S_EMIT;
      S_EMIT: begin
        if (cmd.emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register flag: a finished result waits here for its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `IGDQ_ASSERT_NEXT(a_xfer_starts_mac, clk, rst_n, in_xfer, (state_r == S_MAC) && (cnt_r == '0), "accepted item did not start the mac sequence")
  `IGDQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, in_mac, cnt_r <= CNT_W'(MAC_LAST), "mac counter ran past the drain cycle")
  `IGDQ_ASSERT_NEXT(a_mac_to_acc, clk, rst_n, in_mac && (cnt_r == CNT_W'(MAC_LAST)), state_r == S_ACC, "mac sequence did not end in accumulate")
  `IGDQ_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, cmd.emit, out_valid_r && (state_r == S_IDLE), "emit did not fill the output register")
  `IGDQ_ASSERT_NEXT(a_nonlast_no_emit, clk, rst_n, cmd.acc_add && !sts.last, (state_r == S_IDLE) && (out_valid_r == $past(out_valid_nxt)), "non-last item left the idle path")

endmodule

`default_nettype wire
